/* rtl/core/mlpq_pkg.sv */
// Shared types and constants for the multilevel priority queue core.
// No dependencies.
package mlpq_pkg;

    localparam int CAPACITY_DEF    = 64;
    localparam int LEVELS_DEF      = 5;
    localparam int SOURCE_BITS_DEF = 8;

    typedef enum logic [1:0] {
        OP_SEND    = 2'd0,
        OP_REMOVE  = 2'd1,
        OP_PROMOTE = 2'd2,
        OP_ANNOUNCE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_ENTRY  = 2'd0,
        KIND_ACCEPT = 2'd1,
        KIND_REJECT = 2'd2
    } kind_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  source_id;
        logic [2:0]  level;
        logic [15:0] payload;
        logic [6:0]  count;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  out_source;
        logic [2:0]  out_level;
        logic [15:0] out_payload;
        logic        last;
    } result_t;

endpackage

/* rtl/core/multilevel_priority_queue_purge_promote_core.sv */
// Multilevel priority queue core: LEVELS linked FIFO lists over a shared entry store.
// Depends on mlpq_pkg.
// Send: result registered from S_SEND; S_SEND_LINK follows if the level was not empty.
// Announce: visits levels in S_LV and pops each entry through S_RD and S_EVAL.
// Remove: scans levels in S_LV, each entry in S_RD and S_EVAL; promote adds S_FIX_CUR and
// S_FIX_TAIL per moved entry. Reset empties every list and frees every slot.
module multilevel_priority_queue_purge_promote_core
#(
    parameter int CAPACITY    = mlpq_pkg::CAPACITY_DEF,
    parameter int LEVELS      = mlpq_pkg::LEVELS_DEF,
    parameter int SOURCE_BITS = mlpq_pkg::SOURCE_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  mlpq_pkg::cmd_t    cmd,
    output logic              busy,
    output logic              strobe,
    output mlpq_pkg::result_t result
);
    import mlpq_pkg::*;

    localparam int PW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int LW = $clog2(LEVELS);
    localparam int DW = SOURCE_BITS + 16;
    localparam logic [PW-1:0] NIL = PW'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE, S_SEND, S_SEND_LINK, S_LV, S_RD, S_EVAL, S_FIX_CUR, S_FIX_TAIL
    } state_t;

    // Source and payload of each slot, and the link to the next slot of its list.
    logic [DW-1:0] data_mem [CAPACITY];
    logic [PW-1:0] link_mem [CAPACITY];

    logic [DW-1:0] data_rd_reg;
    logic [PW-1:0] link_rd_reg;
    logic          data_we;
    logic          link_we;
    logic [IW-1:0] data_wa;
    logic [IW-1:0] link_wa;
    logic [DW-1:0] data_wd;
    logic [PW-1:0] link_wd;

    logic [CAPACITY-1:0] used_reg;
    logic [PW-1:0] head_reg [LEVELS];
    logic [PW-1:0] tail_reg [LEVELS];
    state_t        state_reg;
    cmd_t          cmd_reg;
    logic [LW-1:0] lv_reg;
    logic [PW-1:0] cur_reg;
    logic [PW-1:0] prev_reg;
    logic [PW-1:0] nxt_reg;
    logic [PW-1:0] otail_reg;
    logic [PW-1:0] slot_reg;
    logic [6:0]    n_reg;
    logic          strobe_reg;
    logic          strobe_next;
    result_t       result_reg;

    op_t                    op;
    logic [SOURCE_BITS-1:0] csrc;
    logic [SOURCE_BITS-1:0] rd_src;
    logic [15:0]            rd_pay;
    logic [LW-1:0]          slv;
    logic [LW-1:0]          dst;
    logic                   send_ok;
    logic                   match;
    logic                   lv_last;
    logic                   rest_empty;
    logic                   pop_last;
    logic [PW-1:0]          free_slot;

    assign op       = op_t'(cmd_reg.operation);
    assign csrc     = SOURCE_BITS'(cmd_reg.source_id);
    assign rd_src   = data_rd_reg[DW-1:16];
    assign rd_pay   = data_rd_reg[15:0];
    assign slv      = cmd_reg.level[LW-1:0];
    assign dst      = lv_reg - LW'(1);
    assign lv_last  = (lv_reg == LW'(LEVELS - 1));
    assign send_ok  = ({1'b0, cmd_reg.level} < 4'(LEVELS)) && (free_slot != NIL);
    assign match    = (rd_src == csrc);
    // The popped entry is the final beat when the count is reached or nothing is left.
    assign pop_last = (n_reg + 7'd1 == cmd_reg.count) ||
                      (link_rd_reg == NIL && rest_empty);
    assign strobe_next = (state_reg == S_SEND) ||
                         (state_reg == S_EVAL && op == OP_ANNOUNCE);

    // Lowest free slot.
    always_comb
    begin
        free_slot = NIL;
        for (int i = CAPACITY - 1; i >= 0; i--)
            if (!used_reg[i])
                free_slot = PW'(i);
    end

    always_comb
    begin
        rest_empty = 1'b1;
        for (int j = 0; j < LEVELS; j++)
            if (j > int'(lv_reg) && head_reg[j] != NIL)
                rest_empty = 1'b0;
    end

    // One data write and one link write at most per cycle, chosen from state.
    always_comb
    begin
        data_we = 1'b0;
        data_wa = '0;
        data_wd = '0;
        link_we = 1'b0;
        link_wa = '0;
        link_wd = NIL;
        case (state_reg)
            S_SEND:
            begin
                if (send_ok)
                begin
                    data_we = 1'b1;
                    data_wa = free_slot[IW-1:0];
                    data_wd = {csrc, cmd_reg.payload};
                    link_we = 1'b1;
                    link_wa = free_slot[IW-1:0];
                end
            end
            S_SEND_LINK:
            begin
                link_we = 1'b1;
                link_wa = otail_reg[IW-1:0];
                link_wd = slot_reg;
            end
            S_EVAL:
            begin
                // The previous kept entry now skips the unlinked one.
                if (op != OP_ANNOUNCE && match && prev_reg != NIL)
                begin
                    link_we = 1'b1;
                    link_wa = prev_reg[IW-1:0];
                    link_wd = link_rd_reg;
                end
            end
            S_FIX_CUR:
            begin
                link_we = 1'b1;
                link_wa = cur_reg[IW-1:0];
            end
            S_FIX_TAIL:
            begin
                link_we = 1'b1;
                link_wa = otail_reg[IW-1:0];
                link_wd = cur_reg;
            end
            default:
            begin
                link_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (data_we)
            data_mem[data_wa] <= data_wd;
        if (link_we)
            link_mem[link_wa] <= link_wd;
        if (state_reg == S_RD)
        begin
            data_rd_reg <= data_mem[cur_reg[IW-1:0]];
            link_rd_reg <= link_mem[cur_reg[IW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            used_reg   <= '0;
            cmd_reg    <= '0;
            lv_reg     <= '0;
            cur_reg    <= NIL;
            prev_reg   <= NIL;
            nxt_reg    <= NIL;
            otail_reg  <= NIL;
            slot_reg   <= NIL;
            n_reg      <= '0;
            strobe_reg <= 1'b0;
            result_reg <= '0;
            for (int i = 0; i < LEVELS; i++)
            begin
                head_reg[i] <= NIL;
                tail_reg[i] <= NIL;
            end
        end
        else
        begin
            strobe_reg <= strobe_next;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        cmd_reg <= cmd;
                        n_reg   <= '0;
                        case (op_t'(cmd.operation))
                            OP_SEND:
                                state_reg <= S_SEND;
                            OP_PROMOTE:
                            begin
                                lv_reg    <= LW'(1);
                                state_reg <= S_LV;
                            end
                            OP_ANNOUNCE:
                            begin
                                lv_reg <= '0;
                                // A zero count pops nothing and gives no beat.
                                if (cmd.count != 7'd0)
                                    state_reg <= S_LV;
                            end
                            default:
                            begin
                                lv_reg    <= '0;
                                state_reg <= S_LV;
                            end
                        endcase
                    end
                end
                S_SEND:
                begin
                    result_reg <= '{kind: send_ok ? KIND_ACCEPT : KIND_REJECT,
                                    out_source: 8'd0, out_level: 3'd0,
                                    out_payload: 16'd0, last: 1'b1};
                    if (send_ok)
                    begin
                        used_reg[free_slot[IW-1:0]] <= 1'b1;
                        slot_reg  <= free_slot;
                        otail_reg <= tail_reg[slv];
                        if (head_reg[slv] == NIL)
                            head_reg[slv] <= free_slot;
                        tail_reg[slv] <= free_slot;
                    end
                    if (send_ok && tail_reg[slv] != NIL)
                        state_reg <= S_SEND_LINK;
                    else
                        state_reg <= S_IDLE;
                end
                S_SEND_LINK:
                    state_reg <= S_IDLE;
                S_LV:
                begin
                    cur_reg  <= head_reg[lv_reg];
                    prev_reg <= NIL;
                    if (head_reg[lv_reg] != NIL)
                        state_reg <= S_RD;
                    else if (lv_last)
                        state_reg <= S_IDLE;
                    else
                        lv_reg <= lv_reg + LW'(1);
                end
                S_RD:
                    state_reg <= S_EVAL;
                S_EVAL:
                begin
                    nxt_reg <= link_rd_reg;
                    if (op == OP_ANNOUNCE)
                    begin
                        result_reg <= '{kind: KIND_ENTRY, out_source: 8'(rd_src),
                                        out_level: 3'(lv_reg), out_payload: rd_pay,
                                        last: pop_last};
                        used_reg[cur_reg[IW-1:0]] <= 1'b0;
                        head_reg[lv_reg] <= link_rd_reg;
                        if (link_rd_reg == NIL)
                            tail_reg[lv_reg] <= NIL;
                        n_reg <= n_reg + 7'd1;
                        if (pop_last)
                            state_reg <= S_IDLE;
                        else if (link_rd_reg == NIL)
                        begin
                            lv_reg    <= lv_reg + LW'(1);
                            state_reg <= S_LV;
                        end
                        else
                        begin
                            cur_reg   <= link_rd_reg;
                            state_reg <= S_RD;
                        end
                    end
                    else
                    begin
                        if (match)
                        begin
                            if (prev_reg == NIL)
                                head_reg[lv_reg] <= link_rd_reg;
                            if (tail_reg[lv_reg] == cur_reg)
                                tail_reg[lv_reg] <= prev_reg;
                            if (op == OP_PROMOTE)
                            begin
                                // Append to the tail of the level above.
                                otail_reg <= tail_reg[dst];
                                if (head_reg[dst] == NIL)
                                    head_reg[dst] <= cur_reg;
                                tail_reg[dst] <= cur_reg;
                            end
                            else
                                used_reg[cur_reg[IW-1:0]] <= 1'b0;
                        end
                        else
                            prev_reg <= cur_reg;
                        if (match && op == OP_PROMOTE)
                            state_reg <= S_FIX_CUR;
                        else if (link_rd_reg != NIL)
                        begin
                            cur_reg   <= link_rd_reg;
                            state_reg <= S_RD;
                        end
                        else if (lv_last)
                            state_reg <= S_IDLE;
                        else
                        begin
                            lv_reg    <= lv_reg + LW'(1);
                            state_reg <= S_LV;
                        end
                    end
                end
                S_FIX_CUR:
                begin
                    if (otail_reg != NIL)
                        state_reg <= S_FIX_TAIL;
                    else if (nxt_reg != NIL)
                    begin
                        cur_reg   <= nxt_reg;
                        state_reg <= S_RD;
                    end
                    else if (lv_last)
                        state_reg <= S_IDLE;
                    else
                    begin
                        lv_reg    <= lv_reg + LW'(1);
                        state_reg <= S_LV;
                    end
                end
                S_FIX_TAIL:
                begin
                    if (nxt_reg != NIL)
                    begin
                        cur_reg   <= nxt_reg;
                        state_reg <= S_RD;
                    end
                    else if (lv_last)
                        state_reg <= S_IDLE;
                    else
                    begin
                        lv_reg    <= lv_reg + LW'(1);
                        state_reg <= S_LV;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule

/* rtl/core/mlpq_checker.sv */
// Port-level checks for the multilevel priority queue core.
// Depends on mlpq_pkg; bound to the top level below.
module mlpq_checker
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input mlpq_pkg::cmd_t    cmd,
    input logic              busy,
    input logic              strobe,
    input mlpq_pkg::result_t result
);
    import mlpq_pkg::*;

    a_send_one: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.kind != KIND_ENTRY |-> result.last)
        else $error("send result without last");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (result.kind == KIND_ENTRY || result.kind == KIND_ACCEPT ||
                    result.kind == KIND_REJECT))
        else $error("bad kind");

    a_send_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && cmd.operation == OP_SEND |=> busy)
        else $error("busy not raised after send");

    a_send_result: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && cmd.operation == OP_SEND |=>
            ##1 (strobe && result.last && result.kind != KIND_ENTRY))
        else $error("send result missing");

endmodule

bind multilevel_priority_queue_purge_promote_core mlpq_checker u_mlpq_checker
(
    .clk(clk), .rst_n(rst_n), .start(start), .cmd(cmd), .busy(busy),
    .strobe(strobe), .result(result)
);
